@@ src/chte_pkg.sv @@
// ----------------------------------------------------------------------------
// chte_pkg
// Shared widths, command codes and defaults of the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 8;
    localparam int CFG_W    = 7;

    // Defaults for the top-level parameters
    localparam int BUCKETS_DEF = 64;
    localparam int ENTRIES_DEF = 256;

    // Bucket count after reset
    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 7'd64;

    // Remainder unit: key bits folded per cycle and digit steps per key
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = KEY_W / MOD_BITS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR      = 3'd0,
        CMD_INSERT     = 3'd1,
        CMD_LOOKUP     = 3'd2,
        CMD_REMOVE_KEY = 3'd3,
        CMD_REMOVE_HDL = 3'd4
    } t_cmd;

endpackage

@@ src/chained_hash_table_engine_top.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table_engine_top
// Hash map with separate chaining over a pool of node slots named by handle.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) carries one command item: clear, insert,
// lookup, remove by key or remove by handle. Every item gives exactly one
// result item (o_hit, o_found_handle) on the output channel (o_valid / i_ready).
// The bucket count register is written through its own channel (i_cfg_valid /
// o_cfg_ready) by the user while the engine is idle; not enforced by the block.
// Steps per item, from acceptance to result in the output register:
//   insert          : key remainder, head read, node and head write
//   lookup / remove : key remainder, head read, node by node walk, unlink on remove
//   remove by handle: node key fetch, then as remove by key
//   clear           : sweep of both memories
// The remainder unit folds 4 key bits per cycle; the chain walk is bound by
// the single read port of the node memory, one node per cycle.
// After reset the engine sweeps both memories with o_ready low;
// configuration writes are taken meanwhile.
// A finished result waits in the output register while the next item is
// accepted and worked on; the engine only stalls when a second result is
// ready and the first has not been taken.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_top #(
    parameter int BUCKETS = chte_pkg::BUCKETS_DEF,
    parameter int ENTRIES = chte_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [chte_pkg::CMD_W-1:0]    i_command,
    input  logic [chte_pkg::KEY_W-1:0]    i_key,
    input  logic [chte_pkg::HANDLE_W-1:0] i_handle,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic [chte_pkg::HANDLE_W-1:0] o_found_handle,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [chte_pkg::CFG_W-1:0]    i_cfg_bucket_count
);

    localparam int KW   = chte_pkg::KEY_W;
    localparam int LW   = $clog2(ENTRIES + 1);                 // link incl. empty
    localparam int IW   = $clog2(ENTRIES);                     // node index
    localparam int BIW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1; // bucket index
    localparam int NW   = $clog2(BUCKETS + 1);                 // divisor / remainder
    localparam int MAXN = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
    localparam int CW   = $clog2(MAXN);
    localparam int WW   = 1 + LW + KW;                         // node word
    localparam int MB   = chte_pkg::MOD_BITS;

    localparam logic [LW-1:0] NIL      = LW'(ENTRIES);
    localparam logic [CW-1:0] CLR_LAST = CW'(MAXN - 1);
    localparam logic [chte_pkg::MOD_CNT_W-1:0] MOD_LAST =
        chte_pkg::MOD_CNT_W'(chte_pkg::MOD_STEPS - 1);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_NODEK, S_MOD, S_HEAD, S_HEADD, S_WALK, S_UNL
    } t_state;

    typedef struct packed {
        logic          linked;
        logic [LW-1:0] next;
        logic [KW-1:0] key;
    } t_node;

    // memories
    logic [LW-1:0] head_mem [BUCKETS];
    t_node         node_mem [ENTRIES];

    // registers
    t_state                         r_state, n_state;
    logic [chte_pkg::CFG_W-1:0]     r_bucket_count;
    chte_pkg::t_cmd                 r_cmd, n_cmd;
    logic [KW-1:0]                  r_key, n_key;
    logic [KW-1:0]                  r_div, n_div;
    logic [NW-1:0]                  r_rem, n_rem;
    logic [chte_pkg::MOD_CNT_W-1:0] r_mcnt, n_mcnt;
    logic [BIW-1:0]                 r_b, n_b;
    logic [LW-1:0]                  r_h, n_h;
    logic [LW-1:0]                  r_cur, n_cur;
    logic [LW-1:0]                  r_prev, n_prev;
    t_node                          r_prev_word, n_prev_word;
    t_node                          r_cur_word, n_cur_word;
    logic [CW-1:0]                  r_clr, n_clr;
    logic                           r_clr_reply, n_clr_reply;
    logic                           r_done, n_done;
    logic                           r_res_hit, n_res_hit;
    logic [LW-1:0]                  r_res_fh, n_res_fh;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_hit, n_out_hit;
    logic [chte_pkg::HANDLE_W-1:0]  r_out_fh, n_out_fh;

    // memory ports
    t_node          r_node_rd;
    logic [LW-1:0]  r_head_rd;
    logic           node_we, head_we;
    logic [IW-1:0]  node_waddr;
    logic [BIW-1:0] head_waddr;
    t_node          node_wdata;
    logic [LW-1:0]  head_wdata;

    logic [NW-1:0]  divisor;
    logic [NW-1:0]  rem_step;
    logic [NW:0]    rem_t;
    logic           in_acc;
    logic           walk_match;
    logic           slot_free;

    assign o_ready        = (r_state == S_IDLE) && !r_done;
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_found_handle = r_out_fh;
    assign in_acc         = i_valid && o_ready;
    assign slot_free      = !r_out_valid || i_ready;

    // clamp the bucket count into 1..BUCKETS
    always_comb begin
        if (r_bucket_count == '0) begin
            divisor = NW'(1);
        end else if (32'(r_bucket_count) > BUCKETS) begin
            divisor = NW'(BUCKETS);
        end else begin
            divisor = NW'(r_bucket_count);
        end
    end

    // fold the next key digit into the remainder
    always_comb begin
        rem_step = r_rem;
        rem_t    = '0;
        for (int i = 0; i < MB; i++) begin
            rem_t = {rem_step, r_div[KW-1-i]};
            if (rem_t >= {1'b0, divisor}) begin
                rem_t = rem_t - {1'b0, divisor};
            end
            rem_step = rem_t[NW-1:0];
        end
    end

    // chain node match: by key, or by handle for remove by handle
    assign walk_match = (r_cmd == chte_pkg::CMD_REMOVE_HDL) ? (r_cur == r_h)
                                                            : (r_node_rd.key == r_key);

    // next-state and memory control
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_div       = r_div;
        n_rem       = r_rem;
        n_mcnt      = r_mcnt;
        n_b         = r_b;
        n_h         = r_h;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_prev_word = r_prev_word;
        n_cur_word  = r_cur_word;
        n_clr       = r_clr;
        n_clr_reply = r_clr_reply;
        n_done      = r_done;
        n_res_hit   = r_res_hit;
        n_res_fh    = r_res_fh;
        n_out_valid = r_out_valid && !i_ready;
        n_out_hit   = r_out_hit;
        n_out_fh    = r_out_fh;
        node_we     = 1'b0;
        head_we     = 1'b0;
        node_waddr  = r_cur[IW-1:0];
        head_waddr  = r_b;
        node_wdata  = r_cur_word;
        head_wdata  = NIL;

        unique case (r_state)
            // sweep both memories to empty
            S_CLR: begin
                node_waddr = r_clr[IW-1:0];
                node_wdata = '{linked: 1'b0, next: NIL, key: '0};
                node_we    = (32'(r_clr) < ENTRIES);
                head_waddr = r_clr[BIW-1:0];
                head_wdata = NIL;
                head_we    = (32'(r_clr) < BUCKETS);
                n_clr      = r_clr + CW'(1);
                if (r_clr == CLR_LAST) begin
                    n_clr       = '0;
                    n_state     = S_IDLE;
                    n_done      = r_clr_reply;
                    n_res_hit   = 1'b1;
                    n_res_fh    = '0;
                    n_clr_reply = 1'b0;
                end
            end

            // take a command item
            S_IDLE: begin
                if (r_done) begin
                    // hold the result until the output slot frees up
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_out_hit   = r_res_hit;
                        n_out_fh    = chte_pkg::HANDLE_W'(r_res_fh);
                        n_done      = 1'b0;
                    end
                end else if (in_acc) begin
                    n_cmd     = chte_pkg::t_cmd'(i_command);
                    n_key     = i_key;
                    n_div     = i_key;
                    n_rem     = '0;
                    n_mcnt    = '0;
                    n_h       = LW'(i_handle);
                    n_cur     = LW'(i_handle);
                    n_res_hit = 1'b0;
                    n_res_fh  = '0;
                    case (i_command)
                        chte_pkg::CMD_CLEAR: begin
                            n_state     = S_CLR;
                            n_clr       = '0;
                            n_clr_reply = 1'b1;
                        end
                        chte_pkg::CMD_INSERT: begin
                            if (32'(i_handle) < ENTRIES) n_state = S_MOD;
                            else                         n_done  = 1'b1;
                        end
                        chte_pkg::CMD_LOOKUP, chte_pkg::CMD_REMOVE_KEY: begin
                            n_state = S_MOD;
                        end
                        chte_pkg::CMD_REMOVE_HDL: begin
                            if (32'(i_handle) < ENTRIES) n_state = S_NODEK;
                            else                         n_done  = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            // node of the given handle: hash its key if linked
            S_NODEK: begin
                if (r_node_rd.linked) begin
                    n_key   = r_node_rd.key;
                    n_div   = r_node_rd.key;
                    n_state = S_MOD;
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end

            // key modulo bucket count, a digit per cycle
            S_MOD: begin
                n_rem  = rem_step;
                n_div  = r_div << MB;
                n_mcnt = r_mcnt + chte_pkg::MOD_CNT_W'(1);
                if (r_mcnt == MOD_LAST) begin
                    n_b     = BIW'(rem_step);
                    n_state = S_HEAD;
                end
            end

            // head read issued
            S_HEAD: begin
                n_state = S_HEADD;
            end

            // head data: link for insert, start of walk otherwise
            S_HEADD: begin
                if (r_cmd == chte_pkg::CMD_INSERT) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (!r_node_rd.linked) begin
                        node_we    = 1'b1;
                        node_waddr = r_h[IW-1:0];
                        node_wdata = '{linked: 1'b1, next: r_head_rd, key: r_key};
                        head_we    = 1'b1;
                        head_waddr = r_b;
                        head_wdata = r_h;
                        n_res_hit  = 1'b1;
                        n_res_fh   = r_h;
                    end
                end else begin
                    n_prev = NIL;
                    n_cur  = r_head_rd;
                    if (r_head_rd == NIL) begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end

            // one chain node per cycle
            S_WALK: begin
                if (walk_match) begin
                    n_res_hit = 1'b1;
                    n_res_fh  = r_cur;
                    if (r_cmd == chte_pkg::CMD_LOOKUP) begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        // bypass the node, then drop its linked mark
                        if (r_prev == NIL) begin
                            head_we    = 1'b1;
                            head_waddr = r_b;
                            head_wdata = r_node_rd.next;
                        end else begin
                            node_we         = 1'b1;
                            node_waddr      = r_prev[IW-1:0];
                            node_wdata      = r_prev_word;
                            node_wdata.next = r_node_rd.next;
                        end
                        n_cur_word = '{linked: 1'b0, next: NIL, key: r_node_rd.key};
                        n_state    = S_UNL;
                    end
                end else begin
                    n_prev      = r_cur;
                    n_prev_word = r_node_rd;
                    n_cur       = r_node_rd.next;
                    if (r_node_rd.next == NIL) begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end
                end
            end

            // write back the removed node
            S_UNL: begin
                node_we    = 1'b1;
                node_waddr = r_cur[IW-1:0];
                node_wdata = r_cur_word;
                n_state    = S_IDLE;
                n_done     = 1'b1;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        r_node_rd <= node_mem[n_cur[IW-1:0]];
        r_head_rd <= head_mem[r_b];
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLR;
            r_bucket_count <= chte_pkg::BUCKET_COUNT_RST;
            r_clr          <= '0;
            r_clr_reply    <= 1'b0;
            r_done         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_mcnt         <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_clr_reply <= n_clr_reply;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            r_mcnt      <= n_mcnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bucket_count <= i_cfg_bucket_count;
            end
        end
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_div       <= n_div;
        r_rem       <= n_rem;
        r_b         <= n_b;
        r_h         <= n_h;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_prev_word <= n_prev_word;
        r_cur_word  <= n_cur_word;
        r_res_hit   <= n_res_hit;
        r_res_fh    <= n_res_fh;
        r_out_hit   <= n_out_hit;
        r_out_fh    <= n_out_fh;
    end

    // the walk never dereferences an empty link
    a_walk_not_nil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_cur != NIL))
        else $error("chain walk on empty link");

    // the remainder stays below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (r_rem < divisor))
        else $error("remainder out of range");

    // a miss always reports handle zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_found_handle == '0))
        else $error("miss with nonzero handle");

    // a pending result is never overwritten before it is taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped");

endmodule
